@@ src/lbfcd_pkg.sv @@
// shared types, constants and hash step for the layer blend / frame change detect unit
// no dependencies; imported by every module of the block
package lbfcd_pkg;

	// fnv-1a 32-bit constants
	localparam logic [31:0] HASH_INIT  = 32'h811C_9DC5;
	localparam logic [31:0] HASH_PRIME = 32'h0100_0193;

	// alpha code that selects the top pixel as is
	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
	localparam logic [7:0] ALPHA_CLEAR  = 8'h00;
	// rounding bias of the source-over blend
	localparam logic [15:0] ROUND_BIAS = 16'd127;

	// configuration port
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_OVERLAY_EN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_FRAMES = 2'd1;
	localparam logic [3:0] TRAILING_RESET = 4'd2;

	// stream widths
	localparam int unsigned S_DATA_W = 72;
	localparam int unsigned M_DATA_W = 64;

	// one composited pixel with its frame flags
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
		logic       force_send;
		logic       refresh_due;
	} pix_t;

	// pixel plus the hash and the leftover bytes still to fold
	typedef struct packed {
		pix_t        pix;
		logic [31:0] sum;
		logic [23:0] pend;
		logic [1:0]  cnt;
	} fold_t;

	// one result beat
	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic        frame_done;
		logic [31:0] frame_sum;
		logic        changed;
		logic        send;
	} result_t;

	// one fnv-1a step: xor then multiply by the prime
	function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [31:0] w);
		return (h ^ w) * HASH_PRIME;
	endfunction

endpackage

@@ src/lbfcd_blend.sv @@
// input register and source-over blend stage
// depends on lbfcd_pkg
module lbfcd_blend (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [31:0]         top_pixel,
	input  logic [31:0]         under_pixel,
	input  logic                last_pixel,
	input  logic                force_send,
	input  logic                refresh_due,
	input  logic                overlay_en,
	output logic                out_valid,
	input  logic                out_ready,
	output lbfcd_pkg::pix_t     out_pix
);
	import lbfcd_pkg::*;

	logic        valid_s1;
	logic [31:0] top_s1;
	logic [31:0] under_s1;
	logic        last_s1;
	logic        force_s1;
	logic        key_s1;
	logic        valid_s2;
	pix_t        pix_s2;
	logic        ready_s2;
	pix_t        pix_d;
	logic [7:0]  alpha;

	// rounded (t*a + u*(255-a) + 127) / 255, division done as add-and-shift
	function automatic logic [7:0] mix(input logic [7:0] t, input logic [7:0] u,
			input logic [7:0] a);
		logic [15:0] v;
		logic [16:0] q;
		v = {8'd0, t} * {8'd0, a} + {8'd0, u} * {8'd0, ALPHA_OPAQUE - a} + ROUND_BIAS;
		q = {1'b0, v} + 17'd1 + {9'd0, v[15:8]};
		return q[15:8];
	endfunction

	assign ready_s2 = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || ready_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			top_s1   <= top_pixel;
			under_s1 <= under_pixel;
			last_s1  <= last_pixel;
			force_s1 <= force_send;
			key_s1   <= refresh_due;
		end
	end

	// layer select and blend
	assign alpha = top_s1[31:24];

	always_comb begin
		pix_d.last        = last_s1;
		pix_d.force_send  = force_s1;
		pix_d.refresh_due = key_s1;
		if (overlay_en && alpha == ALPHA_CLEAR) begin
			pix_d.red   = under_s1[23:16];
			pix_d.green = under_s1[15:8];
			pix_d.blue  = under_s1[7:0];
		end else if (overlay_en && alpha != ALPHA_OPAQUE) begin
			pix_d.red   = mix(top_s1[23:16], under_s1[23:16], alpha);
			pix_d.green = mix(top_s1[15:8], under_s1[15:8], alpha);
			pix_d.blue  = mix(top_s1[7:0], under_s1[7:0], alpha);
		end else begin
			pix_d.red   = top_s1[23:16];
			pix_d.green = top_s1[15:8];
			pix_d.blue  = top_s1[7:0];
		end
	end

	// blend result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			pix_s2 <= pix_d;
		end
	end

	assign out_valid = valid_s2;
	assign out_pix   = pix_s2;

endmodule

@@ src/lbfcd_hash.sv @@
// byte packing and running fnv-1a word fold, one word per pixel at most
// depends on lbfcd_pkg
module lbfcd_hash (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  lbfcd_pkg::pix_t  in_pix,
	output logic             out_valid,
	input  logic             out_ready,
	output lbfcd_pkg::fold_t out_fold
);
	import lbfcd_pkg::*;

	logic [31:0] hash_q;
	logic [23:0] pend_q;
	logic [1:0]  cnt_q;
	logic        valid_s3;
	fold_t       fold_s3;
	logic        take;
	logic [47:0] stream;
	logic        word_full;
	logic [31:0] hash_d;
	logic [23:0] left_d;
	logic [1:0]  cnt_d;

	assign in_ready = !valid_s3 || out_ready;
	assign take     = in_valid && in_ready;

	// pending bytes followed by r, g, b, first byte lowest
	assign stream    = {24'd0, pend_q}
		| ({24'd0, in_pix.blue, in_pix.green, in_pix.red} << {cnt_q, 3'b000});
	assign word_full = cnt_q != 2'd0;
	assign hash_d    = word_full ? fnv_step(hash_q, stream[31:0]) : hash_q;
	assign left_d    = word_full ? {8'd0, stream[47:32]} : stream[23:0];
	assign cnt_d     = cnt_q + 2'd3;

	// running state, reloaded at frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= HASH_INIT;
			pend_q <= 24'd0;
			cnt_q  <= 2'd0;
		end else if (take) begin
			if (in_pix.last) begin
				hash_q <= HASH_INIT;
				pend_q <= 24'd0;
				cnt_q  <= 2'd0;
			end else begin
				hash_q <= hash_d;
				pend_q <= left_d;
				cnt_q  <= cnt_d;
			end
		end
	end

	// stage register toward the tail fold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			fold_s3.pix  <= in_pix;
			fold_s3.sum  <= hash_d;
			fold_s3.pend <= left_d;
			fold_s3.cnt  <= cnt_d;
		end
	end

	assign out_valid = valid_s3;
	assign out_fold  = fold_s3;

	// frame end leaves a fresh hash and no pending bytes
	a_frame_reload: assert property (@(posedge clk) disable iff (!arst_n)
		take && in_pix.last |=> hash_q == HASH_INIT && cnt_q == 2'd0 && pend_q == 24'd0)
		else $error("hash state not reloaded after frame end");

	// bytes above the fill level stay clear
	a_pend_clean_lo: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd0 |-> pend_q == 24'd0)
		else $error("stale pending bytes with empty fill");

	a_pend_clean_hi: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != 2'd1 || pend_q[23:8] == 16'd0) && (cnt_q != 2'd2 || pend_q[23:16] == 8'd0))
		else $error("pending bytes above fill level");

endmodule

@@ src/lbfcd_tail.sv @@
// one single-byte fold of the frame-end leftovers, one register stage
// depends on lbfcd_pkg
module lbfcd_tail (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  lbfcd_pkg::fold_t in_fold,
	output logic             out_valid,
	input  logic             out_ready,
	output lbfcd_pkg::fold_t out_fold
);
	import lbfcd_pkg::*;

	logic  valid_q;
	fold_t fold_q;
	fold_t fold_d;

	assign in_ready = !valid_q || out_ready;

	// fold the lowest leftover byte on a last pixel and shift the rest down
	always_comb begin
		fold_d = in_fold;
		if (in_fold.pix.last && in_fold.cnt != 2'd0) begin
			fold_d.sum  = fnv_step(in_fold.sum, {24'd0, in_fold.pend[7:0]});
			fold_d.pend = {8'd0, in_fold.pend[23:8]};
			fold_d.cnt  = in_fold.cnt - 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			fold_q <= fold_d;
		end
	end

	assign out_valid = valid_q;
	assign out_fold  = fold_q;

endmodule

@@ src/lbfcd_verdict.sv @@
// frame verdict: change compare, trailing counter, send flag, result register
// depends on lbfcd_pkg
module lbfcd_verdict (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  lbfcd_pkg::fold_t   in_fold,
	input  logic [3:0]         hold_frames,
	output logic               out_valid,
	input  logic               out_ready,
	output lbfcd_pkg::result_t out_res
);
	import lbfcd_pkg::*;

	logic    valid_q;
	result_t res_q;
	result_t res_d;
	logic [31:0] last_sent_q;
	logic        have_sent_q;
	logic [3:0]  trail_q;
	logic [3:0]  trail_d;
	logic        chg;
	logic        snd;
	logic        take;

	assign in_ready = !valid_q || out_ready;
	assign take     = in_valid && in_ready;

	// compare and counter update
	assign chg     = !have_sent_q || in_fold.sum != last_sent_q;
	assign trail_d = chg ? hold_frames : (trail_q != 4'd0 ? trail_q - 4'd1 : trail_q);
	assign snd     = chg || in_fold.pix.force_send || trail_d != 4'd0
		|| in_fold.pix.refresh_due;

	always_comb begin
		res_d.red        = in_fold.pix.red;
		res_d.green      = in_fold.pix.green;
		res_d.blue       = in_fold.pix.blue;
		res_d.frame_done = in_fold.pix.last;
		res_d.frame_sum  = in_fold.pix.last ? in_fold.sum : 32'd0;
		res_d.changed    = in_fold.pix.last && chg;
		res_d.send       = in_fold.pix.last && snd;
	end

	// sent-sum state, updated on frame-end beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_sent_q <= 32'd0;
			have_sent_q <= 1'b0;
			trail_q     <= 4'd0;
		end else if (take && in_fold.pix.last) begin
			trail_q <= trail_d;
			if (snd) begin
				last_sent_q <= in_fold.sum;
				have_sent_q <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_d;
		end
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;

endmodule

@@ src/layer_blend_frame_change_detect_unit.sv @@
// top level of the layer blend / frame change detect unit
// depends on lbfcd_pkg, lbfcd_blend, lbfcd_hash, lbfcd_tail, lbfcd_verdict

// Takes one pixel pair per clock and returns one composited pixel per clock, in order,
// while the output is not stalled. The result beat passes through seven register stages
// (input register, blend, word fold, three single-byte folds of the frame-end leftovers,
// result register). The rate is set by the running hash, which folds at most one packed
// 32-bit word per pixel through a single constant multiply each cycle. Each stage has
// its own ready, so a stalled output only backs up as far as needed and the input keeps
// taking beats until the pipe is full. The beat carrying s_tlast closes the frame: its
// result has m_tlast set with the frame checksum, changed and send flags; other beats
// carry zeros there. No clearing pass after reset. Configuration writes are taken at any
// time but must only be issued while idle.
module layer_blend_frame_change_detect_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	// top_pixel[31:0], under_pixel[63:32], force_send[64], refresh_due[65], zero fill
	input  logic [lbfcd_pkg::S_DATA_W-1:0] s_tdata,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic                           s_tlast,
	// red[7:0], green[15:8], blue[23:16], frame_sum[55:24], changed[56], send[57], zero fill
	output logic [lbfcd_pkg::M_DATA_W-1:0] m_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic                           m_tlast,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [lbfcd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lbfcd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lbfcd_pkg::*;

	logic       overlay_en_q;
	logic [3:0] hold_frames_q;

	logic    blend_valid, blend_ready;
	pix_t    blend_pix;
	logic    hash_valid, hash_ready;
	fold_t   hash_fold;
	logic    t0_valid, t0_ready;
	fold_t   t0_fold;
	logic    t1_valid, t1_ready;
	fold_t   t1_fold;
	logic    t2_valid, t2_ready;
	fold_t   t2_fold;
	result_t res;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overlay_en_q  <= 1'b1;
			hold_frames_q <= TRAILING_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_OVERLAY_EN:  overlay_en_q  <= cfg_data[0];
				CFG_HOLD_FRAMES: hold_frames_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// pipeline
	lbfcd_blend u_blend (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.top_pixel    (s_tdata[31:0]),
		.under_pixel  (s_tdata[63:32]),
		.last_pixel   (s_tlast),
		.force_send   (s_tdata[64]),
		.refresh_due  (s_tdata[65]),
		.overlay_en   (overlay_en_q),
		.out_valid    (blend_valid),
		.out_ready    (blend_ready),
		.out_pix      (blend_pix)
	);

	lbfcd_hash u_hash (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (blend_valid),
		.in_ready  (blend_ready),
		.in_pix    (blend_pix),
		.out_valid (hash_valid),
		.out_ready (hash_ready),
		.out_fold  (hash_fold)
	);

	lbfcd_tail u_tail0 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (hash_valid),
		.in_ready  (hash_ready),
		.in_fold   (hash_fold),
		.out_valid (t0_valid),
		.out_ready (t0_ready),
		.out_fold  (t0_fold)
	);

	lbfcd_tail u_tail1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (t0_valid),
		.in_ready  (t0_ready),
		.in_fold   (t0_fold),
		.out_valid (t1_valid),
		.out_ready (t1_ready),
		.out_fold  (t1_fold)
	);

	lbfcd_tail u_tail2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (t1_valid),
		.in_ready  (t1_ready),
		.in_fold   (t1_fold),
		.out_valid (t2_valid),
		.out_ready (t2_ready),
		.out_fold  (t2_fold)
	);

	lbfcd_verdict u_verdict (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (t2_valid),
		.in_ready    (t2_ready),
		.in_fold     (t2_fold),
		.hold_frames (hold_frames_q),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_res     (res)
	);

	// output beat packing
	assign m_tdata = {6'd0, res.send, res.changed, res.frame_sum, res.blue, res.green, res.red};
	assign m_tlast = res.frame_done;

	// mid-frame beats carry no verdict
	a_mid_frame_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[57:24] == 34'd0)
		else $error("verdict fields set on a mid-frame beat");

	// a changed frame is always sent
	a_changed_sends: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[56] |-> m_tdata[57] && m_tlast)
		else $error("changed frame without send");

endmodule

@@ tb/lbfcd_checker.sv @@
// result checker for the layer blend / frame change detect unit: predicts every output beat
// from the accepted input and config beats and compares them in order; depends on lbfcd_pkg
module lbfcd_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [lbfcd_pkg::S_DATA_W-1:0]   s_tdata,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic                             s_tlast,
	input  logic [lbfcd_pkg::M_DATA_W-1:0]   m_tdata,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic                             m_tlast,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [lbfcd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lbfcd_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                               errors,
	output int                               outstanding
);
	import lbfcd_pkg::*;

	// shadow of the configuration registers
	logic        overlay_on;
	logic [3:0]  trail_reload;

	// shadow of the hash and verdict state
	logic [31:0] frame_hash;
	logic [23:0] held_bytes;
	logic [1:0]  held_count;
	logic [31:0] sent_sum;
	logic        sent_valid;
	logic [3:0]  trail_count;

	result_t     expected_pixels[$];
	int          mismatches;
	result_t     got_pixel;
	result_t     want_pixel;
	result_t     new_pixel;

	// rounded source-over mix of one channel
	function automatic logic [7:0] over_mix(input logic [7:0] t, input logic [7:0] u,
		input logic [7:0] a);
		int unsigned acc;
		acc = t * a + u * (255 - a) + 127;
		return 8'(acc / 255);
	endfunction

	// add one byte to the stream, folding a full little-endian word
	task fold_byte(input logic [7:0] b);
		if (held_count == 2'd3) begin
			frame_hash = (frame_hash ^ {b, held_bytes}) * HASH_PRIME;
			held_bytes = '0;
			held_count = '0;
		end else begin
			held_bytes = held_bytes | (24'(b) << (8 * held_count));
			held_count = held_count + 2'd1;
		end
	endtask

	// composite one pixel pair, advance the hash and form the frame verdict on the last pixel
	task composite_and_hash(input logic [31:0] top, input logic [31:0] under,
		input logic is_last, input logic force_flag, input logic key_flag,
		output result_t r);
		logic [7:0]  alpha;
		logic [31:0] sum;
		int          i;
		alpha = top[31:24];
		r = '0;
		if (overlay_on && alpha == ALPHA_CLEAR) begin
			r.red   = under[23:16];
			r.green = under[15:8];
			r.blue  = under[7:0];
		end else if (overlay_on && alpha != ALPHA_OPAQUE) begin
			r.red   = over_mix(top[23:16], under[23:16], alpha);
			r.green = over_mix(top[15:8], under[15:8], alpha);
			r.blue  = over_mix(top[7:0], under[7:0], alpha);
		end else begin
			r.red   = top[23:16];
			r.green = top[15:8];
			r.blue  = top[7:0];
		end
		fold_byte(r.red);
		fold_byte(r.green);
		fold_byte(r.blue);
		if (is_last) begin
			// leftover bytes are folded one at a time
			sum = frame_hash;
			for (i = 0; i < held_count; i++)
				sum = (sum ^ {24'd0, held_bytes[8*i +: 8]}) * HASH_PRIME;
			r.frame_done = 1'b1;
			r.frame_sum  = sum;
			r.changed    = !sent_valid || sum != sent_sum;
			if (r.changed)
				trail_count = trail_reload;
			else if (trail_count != 4'd0)
				trail_count = trail_count - 4'd1;
			r.send = r.changed || force_flag || trail_count != 4'd0 || key_flag;
			if (r.send) begin
				sent_sum   = sum;
				sent_valid = 1'b1;
			end
			frame_hash = HASH_INIT;
			held_bytes = '0;
			held_count = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overlay_on   = 1'b1;
			trail_reload = TRAILING_RESET;
			frame_hash   = HASH_INIT;
			held_bytes   = '0;
			held_count   = '0;
			sent_sum     = '0;
			sent_valid   = 1'b0;
			trail_count  = '0;
			mismatches   = 0;
			expected_pixels.delete();
			errors      <= 0;
			outstanding <= 0;
		end else begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_OVERLAY_EN: begin
						overlay_on = cfg_data[0];
					end
					CFG_HOLD_FRAMES: begin
						trail_reload = cfg_data;
					end
					default: begin
					end
				endcase
			end
			// output beat against the oldest expectation
			if (m_tvalid && m_tready) begin
				got_pixel.red        = m_tdata[7:0];
				got_pixel.green      = m_tdata[15:8];
				got_pixel.blue       = m_tdata[23:16];
				got_pixel.frame_done = m_tlast;
				got_pixel.frame_sum  = m_tdata[55:24];
				got_pixel.changed    = m_tdata[56];
				got_pixel.send       = m_tdata[57];
				if (expected_pixels.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: output beat with nothing expected, data %h last %b",
							m_tdata, m_tlast);
				end else begin
					want_pixel = expected_pixels.pop_front();
					if (got_pixel.red !== want_pixel.red
						|| got_pixel.green !== want_pixel.green
						|| got_pixel.blue !== want_pixel.blue
						|| got_pixel.frame_done !== want_pixel.frame_done
						|| got_pixel.frame_sum !== want_pixel.frame_sum
						|| got_pixel.changed !== want_pixel.changed
						|| got_pixel.send !== want_pixel.send) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch: expected rgb %h %h %h done %b sum %h chg %b send %b",
								want_pixel.red, want_pixel.green, want_pixel.blue,
								want_pixel.frame_done, want_pixel.frame_sum,
								want_pixel.changed, want_pixel.send);
							$display("          got      rgb %h %h %h done %b sum %h chg %b send %b",
								got_pixel.red, got_pixel.green, got_pixel.blue,
								got_pixel.frame_done, got_pixel.frame_sum,
								got_pixel.changed, got_pixel.send);
						end
					end
				end
			end
			// input beat
			if (s_tvalid && s_tready) begin
				composite_and_hash(s_tdata[31:0], s_tdata[63:32], s_tlast, s_tdata[64],
					s_tdata[65], new_pixel);
				expected_pixels.push_back(new_pixel);
			end
			errors      <= mismatches;
			outstanding <= expected_pixels.size();
		end
	end

endmodule

@@ tb/layer_blend_frame_change_detect_unit_tb.sv @@
// top of the testbench: clock, reset, pixel stream, output stalls, register writes and verdict
// depends on lbfcd_pkg, layer_blend_frame_change_detect_unit and lbfcd_checker
module layer_blend_frame_change_detect_unit_tb;
	import lbfcd_pkg::*;

	localparam int LATENCY   = 7;
	localparam int WD_LIMIT  = 1000;
	localparam int LONG_HOLD = 80;
	localparam int PHASE_LEN = 255;
	localparam int MAX_FRAME = 48;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic [S_DATA_W-1:0]   s_tdata = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic                  s_tlast = 1'b0;
	logic [M_DATA_W-1:0]   m_tdata;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic                  m_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int errors;
	int outstanding;

	// sender burst control
	int burst_left = 0;
	bit steady = 1'b0;

	// previous frame, kept for replays
	logic [31:0] prev_top[MAX_FRAME];
	logic [31:0] prev_under[MAX_FRAME];
	int          prev_len = 0;

	// receiver state
	int rx_beats = 0;
	int rx_cycle = 0;
	int rx_mode = 0;
	int rx_mode_left = 0;
	int hold_left = 0;
	int holds_done = 0;

	int idle_cycles = 0;

	always #10 clk = ~clk;

	layer_blend_frame_change_detect_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tlast   (s_tlast),
		.m_tdata   (m_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	lbfcd_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tdata     (s_tdata),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tlast     (s_tlast),
		.m_tdata     (m_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tlast     (m_tlast),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.errors      (errors),
		.outstanding (outstanding)
	);

	// offer one pixel beat, with a random gap at the start of each burst unless steady is set
	task automatic put_pixel(input logic [31:0] top, input logic [31:0] under,
		input logic is_last, input logic force_flag, input logic key_flag);
		int gap;
		if (!steady && burst_left <= 0) begin
			gap = $urandom_range(1, 8);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 32);
		end
		s_tdata  <= {6'd0, key_flag, force_flag, under, top};
		s_tlast  <= is_last;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		burst_left--;
	endtask

	// stop offering and wait until every expected beat has come out
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (LATENCY + 3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// top pixel with alpha biased toward the clear, opaque and near-edge codes
	function automatic logic [31:0] rand_top();
		logic [31:0] px;
		px = $urandom();
		case ($urandom_range(0, 7)) inside
			[0:1]: px[31:24] = ALPHA_CLEAR;
			[2:3]: px[31:24] = ALPHA_OPAQUE;
			4: px[31:24] = ($urandom_range(0, 1) == 0) ? 8'h01 : 8'hFE;
			default: begin
			end
		endcase
		return px;
	endfunction

	// random well-formed frames: new content, exact replays, replays with a tweak
	task automatic run_frames(input int n_items);
		logic [31:0] cur_top[MAX_FRAME];
		logic [31:0] cur_under[MAX_FRAME];
		int          sent;
		int          len;
		int          kind;
		int          i;
		int          pick;
		sent = 0;
		while (sent < n_items) begin
			kind = $urandom_range(0, 19);
			if (prev_len == 0)
				kind = 0;
			if (kind < 6) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, MAX_FRAME)
					: $urandom_range(1, 12);
				for (i = 0; i < len; i++) begin
					cur_top[i]   = rand_top();
					cur_under[i] = $urandom();
				end
			end else begin
				len = prev_len;
				for (i = 0; i < len; i++) begin
					cur_top[i]   = prev_top[i];
					cur_under[i] = prev_under[i];
				end
				pick = $urandom_range(0, len - 1);
				// replay with one flipped bit of a top pixel
				if (kind >= 13 && kind < 16)
					cur_top[pick][$urandom_range(0, 31)] ^= 1'b1;
				// replay with a new lower layer, unchanged wherever it does not show
				else if (kind >= 16)
					for (i = 0; i < len; i++)
						cur_under[i] = $urandom();
			end
			steady = ($urandom_range(0, 4) == 0);
			for (i = 0; i < len; i++)
				put_pixel(cur_top[i], cur_under[i], i == len - 1,
					$urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
			for (i = 0; i < len; i++) begin
				prev_top[i]   = cur_top[i];
				prev_under[i] = cur_under[i];
			end
			prev_len = len;
			sent += len;
		end
		steady = 1'b0;
	endtask

	// receiver: stall patterns that change at random, plus long hold-offs under load
	always @(posedge clk) begin
		rx_cycle++;
		if (m_tvalid && m_tready)
			rx_beats++;
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (holds_done < 2 && rx_beats >= 500 + 500 * holds_done && s_tvalid) begin
			hold_left = LONG_HOLD;
			holds_done++;
			m_tready <= 1'b0;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode      = $urandom_range(0, 3);
				rx_mode_left = $urandom_range(20, 200);
			end else begin
				rx_mode_left--;
			end
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= (rx_cycle % 4) != 3;
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WD_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		logic [0:5] ph_overlay;
		logic [3:0] ph_trail[6];
		int         p;
		ph_overlay = 6'b101101;
		ph_trail   = '{4'd2, 4'd0, 4'd15, 4'd0, 4'd15, 4'd0};
		ph_trail[5] = 4'($urandom_range(1, 14));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: clear alpha shows the lower pixel, repeated single-pixel frames
		put_pixel(32'h00FF_FFFF, 32'h0012_3456, 1'b1, 1'b0, 1'b0);
		put_pixel(32'h00FF_FFFF, 32'h0012_3456, 1'b1, 1'b0, 1'b0);
		put_pixel(32'h00FF_FFFF, 32'h0012_3456, 1'b1, 1'b0, 1'b0);
		put_pixel(32'h00FF_FFFF, 32'h0012_3456, 1'b1, 1'b1, 1'b0);
		put_pixel(32'h00FF_FFFF, 32'h0012_3456, 1'b1, 1'b0, 1'b1);
		// two pixels, flags on a non-last pixel are ignored
		put_pixel(32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b1, 1'b1);
		put_pixel(32'h01FF_00FF, 32'h0000_FF00, 1'b1, 1'b0, 1'b0);
		// three pixels with near-edge and mid alphas
		put_pixel(32'hFEFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 1'b0);
		put_pixel(32'h80FF_00FF, 32'h00FF_FF00, 1'b0, 1'b0, 1'b0);
		put_pixel(32'h7F00_FF00, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
		// four pixels, no leftover bytes at frame end
		put_pixel(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b0);
		put_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
		put_pixel(32'h0100_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
		put_pixel(32'hFE00_0000, 32'h00FF_FFFF, 1'b1, 1'b0, 1'b0);
		// five random pixels
		repeat (4) put_pixel(rand_top(), $urandom(), 1'b0, 1'b0, 1'b0);
		put_pixel(rand_top(), $urandom(), 1'b1, 1'b0, 1'b0);
		// overlay off: top passes whatever its alpha
		drain();
		write_reg(CFG_OVERLAY_EN, 4'd0);
		write_reg(CFG_HOLD_FRAMES, 4'd15);
		put_pixel(32'h40AB_CDEF, 32'h0011_2233, 1'b0, 1'b0, 1'b0);
		put_pixel(32'h00FE_DCBA, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
		put_pixel(32'h00FE_DCBA, 32'h0000_0000, 1'b1, 1'b0, 1'b0);

		// random phases over several register settings
		for (p = 0; p < 6; p++) begin
			drain();
			write_reg(CFG_OVERLAY_EN, {3'd0, ph_overlay[p]});
			write_reg(CFG_HOLD_FRAMES, ph_trail[p]);
			run_frames(PHASE_LEN);
		end

		drain();
		if (errors == 0 && outstanding == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
